### hdl/mtc_pkg.sv
// Shared types and constants for the Morse trie codec.
`default_nettype none

package mtc_pkg;

    localparam int CHAR_W           = 8;
    localparam int CODE_W           = 9;
    localparam int LEN_W            = 4;
    localparam int FUNC_W           = 2;
    localparam int KIND_W           = 3;
    localparam int REV_DEPTH        = 256;
    localparam int DEF_MAX_CODE_LEN = 9;

    localparam logic [CHAR_W-1:0] CH_DOT      = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH     = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LOWER_A  = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 8'd122;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DECODE = 2'd1,
        FUNC_ENCODE = 2'd2
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KIND_LETTER     = 3'd0,
        KIND_WORD_SPACE = 3'd1,
        KIND_CODE       = 3'd2,
        KIND_WORD_SEP   = 3'd3,
        KIND_UNKNOWN    = 3'd4,
        KIND_TOO_LONG   = 3'd5
    } t_kind;

    // table write request for an insert
    typedef struct packed {
        logic              vld;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_ins_req;

    // registered reverse table read
    typedef struct packed {
        logic              present;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_rev_rd;

endpackage

`default_nettype wire

### hdl/mtc_tables.sv
// Node table (heap-ordered trie) and reverse table, with post-reset clear sweep.
`default_nettype none

module mtc_tables
    import mtc_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_ins_req                i_ins,
    input  logic [MAX_CODE_LEN-1:0] i_dec_bits,
    input  logic [LEN_W-1:0]        i_dec_len,
    input  logic [CHAR_W-1:0]       i_enc_char,
    input  logic [CODE_W-1:0]       i_chk_code,
    input  logic [LEN_W-1:0]        i_chk_len,
    output logic                    o_busy,
    output logic [CHAR_W-1:0]       o_dec_char,
    output t_rev_rd                 o_rev,
    output logic [CHAR_W-1:0]       o_chk_char
);

    localparam int AW         = MAX_CODE_LEN + 1;
    localparam int NODE_DEPTH = 1 << AW;
    localparam int REV_W      = LEN_W + CODE_W;

    // root is 1; symbol k of a len-symbol path lands at bit len-1-k
    function automatic logic [AW-1:0] node_of(input logic [MAX_CODE_LEN-1:0] bits,
                                              input logic [LEN_W-1:0] len);
        logic [MAX_CODE_LEN-1:0] rev;
        logic [LEN_W-1:0]        sh;
        for (int k = 0; k < MAX_CODE_LEN; k++) begin
            rev[MAX_CODE_LEN-1-k] = bits[k];
        end
        sh = LEN_W'(MAX_CODE_LEN) - len;
        return (AW'(1) << len) | AW'(rev >> sh);
    endfunction

    logic [CHAR_W-1:0] r_node_mem [NODE_DEPTH];
    logic [REV_W-1:0]  r_rev_mem  [REV_DEPTH];
    logic [REV_DEPTH-1:0] r_rev_vld;

    logic [AW-1:0]     r_clr_addr;
    logic              r_clr_busy;

    logic [CHAR_W-1:0] r_dec_rd;
    logic [CHAR_W-1:0] r_chk_rd;
    logic [REV_W-1:0]  r_rev_rd;
    logic              r_rev_rd_vld;

    logic              node_wr;
    logic [AW-1:0]     node_wr_addr;
    logic [CHAR_W-1:0] node_wr_data;
    logic              rev_wr;
    logic [AW-1:0]     dec_addr;
    logic [AW-1:0]     chk_addr;

    assign node_wr      = r_clr_busy || (i_en && i_ins.vld);
    assign node_wr_addr = r_clr_busy ? r_clr_addr
                                     : node_of(MAX_CODE_LEN'(i_ins.code), i_ins.len);
    assign node_wr_data = r_clr_busy ? '0 : i_ins.ch;
    assign rev_wr       = i_en && i_ins.vld && (i_ins.ch != '0);
    assign dec_addr     = node_of(i_dec_bits, i_dec_len);
    assign chk_addr     = node_of(MAX_CODE_LEN'(i_chk_code), i_chk_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {AW{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (node_wr) begin
            r_node_mem[node_wr_addr] <= node_wr_data;
        end
        if (i_en) begin
            r_dec_rd <= r_node_mem[dec_addr];
            r_chk_rd <= r_node_mem[chk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rev_wr) begin
            r_rev_mem[i_ins.ch] <= {i_ins.len, i_ins.code};
        end
        if (i_en) begin
            r_rev_rd <= r_rev_mem[i_enc_char];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev_vld    <= '0;
            r_rev_rd_vld <= 1'b0;
        end else begin
            if (rev_wr) begin
                r_rev_vld[i_ins.ch] <= 1'b1;
            end
            if (i_en) begin
                r_rev_rd_vld <= r_rev_vld[i_enc_char];
            end
        end
    end

    assign o_busy       = r_clr_busy;
    assign o_dec_char   = r_dec_rd;
    assign o_chk_char   = r_chk_rd;
    assign o_rev.present = r_rev_rd_vld;
    assign o_rev.len     = r_rev_rd[REV_W-1:CODE_W];
    assign o_rev.code    = r_rev_rd[CODE_W-1:0];

endmodule

`default_nettype wire

### hdl/morse_trie_codec_unit.sv
// Top level of the Morse trie codec: input stage, decode state, result pipeline.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+------------------------------------------------------
//  input   | i_valid | o_ready | i_func i_char_value i_path_bits i_path_len i_phrase_end
//  output  | o_valid | i_ready | o_kind o_letter o_code_bits o_code_len o_end_of_phrase
//
// One transaction per cycle while o_ready is high; a result passes through the input register,
// node/reverse read, node check read and result register.
// After reset the node table is swept to zero, all 2^(MAX_CODE_LEN+1) entries
// (1024 by default), with o_ready low.
// A stalled result holds the whole pipeline; inserts and ignored symbols give no result.
// An encode is confirmed by reading back the node its reverse entry points at.
`default_nettype none

module morse_trie_codec_unit
    import mtc_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [CHAR_W-1:0] i_char_value,
    input  logic [CODE_W-1:0] i_path_bits,
    input  logic [LEN_W-1:0]  i_path_len,
    input  logic              i_phrase_end,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [KIND_W-1:0] o_kind,
    output logic [CHAR_W-1:0] o_letter,
    output logic [CODE_W-1:0] o_code_bits,
    output logic [LEN_W-1:0]  o_code_len,
    output logic              o_end_of_phrase
);

    logic en;
    logic busy;

    // stage A: input register
    logic              r_a_valid;
    logic [FUNC_W-1:0] r_a_func;
    logic [CHAR_W-1:0] r_a_char;
    logic [CODE_W-1:0] r_a_pbits;
    logic [LEN_W-1:0]  r_a_plen;
    logic              r_a_eop;

    // pending decode code
    logic [MAX_CODE_LEN-1:0] r_pend_bits, n_pend_bits;
    logic [LEN_W-1:0]        r_pend_len, n_pend_len;
    logic                    r_pend_ovf, n_pend_ovf;

    // stage B
    logic              r_b_valid, n_b_valid;
    t_kind             r_b_kind, n_b_kind;
    logic              r_b_lookup, n_b_lookup;
    logic              r_b_enc, n_b_enc;
    logic              r_b_eop, n_b_eop;
    logic [CHAR_W-1:0] r_b_char;

    // stage C
    logic              r_c_valid;
    t_kind             r_c_kind;
    logic [CHAR_W-1:0] r_c_letter;
    logic              r_c_eop;
    logic              r_c_enc;
    logic [CHAR_W-1:0] r_c_char;
    t_rev_rd           r_c_rev;

    // result register
    logic              r_o_valid;
    t_kind             r_o_kind;
    logic [CHAR_W-1:0] r_o_letter;
    logic [CODE_W-1:0] r_o_code_bits;
    logic [LEN_W-1:0]  r_o_code_len;
    logic              r_o_eop;

    logic [MAX_CODE_LEN-1:0] upd_bits;
    logic [LEN_W-1:0]        upd_len;
    logic                    upd_ovf;
    logic                    is_dot, is_dash, is_space, is_slash;
    logic [CHAR_W-1:0]       upper;
    logic [CODE_W-1:0]       ins_mask;
    t_ins_req                ins;

    logic [CHAR_W-1:0] dec_char;
    logic [CHAR_W-1:0] chk_char;
    t_rev_rd           rev;
    logic              enc_hit;

    assign en      = !busy && (!r_o_valid || i_ready);
    assign o_ready = en;

    assign is_dot   = (r_a_char == CH_DOT);
    assign is_dash  = (r_a_char == CH_DASH);
    assign is_space = (r_a_char == CH_SPACE);
    assign is_slash = (r_a_char == CH_SLASH);
    assign upper    = (r_a_char >= CH_LOWER_A && r_a_char <= CH_LOWER_Z)
                      ? r_a_char - CASE_OFFSET : r_a_char;
    assign ins_mask = ~({CODE_W{1'b1}} << r_a_plen);

    // symbol applied to the pending code
    always_comb begin
        upd_bits = r_pend_bits;
        upd_len  = r_pend_len;
        upd_ovf  = r_pend_ovf;
        if (is_dot || is_dash) begin
            if (r_pend_len < LEN_W'(MAX_CODE_LEN)) begin
                if (is_dash) begin
                    upd_bits = r_pend_bits | (MAX_CODE_LEN'(1) << r_pend_len);
                end
                upd_len = r_pend_len + 1'b1;
            end else begin
                upd_ovf = 1'b1;
            end
        end
    end

    always_comb begin
        n_b_valid   = 1'b0;
        n_b_kind    = KIND_UNKNOWN;
        n_b_lookup  = 1'b0;
        n_b_enc     = 1'b0;
        n_b_eop     = 1'b0;
        n_pend_bits = r_pend_bits;
        n_pend_len  = r_pend_len;
        n_pend_ovf  = r_pend_ovf;
        ins         = '0;
        if (r_a_valid) begin
            unique case (t_func'(r_a_func))
                FUNC_INSERT: begin
                    if (r_a_plen != '0 && r_a_plen <= LEN_W'(MAX_CODE_LEN)) begin
                        ins.vld  = 1'b1;
                        ins.ch   = r_a_char;
                        ins.len  = r_a_plen;
                        ins.code = r_a_pbits & ins_mask;
                    end
                end
                FUNC_DECODE: begin
                    n_pend_bits = upd_bits;
                    n_pend_len  = upd_len;
                    n_pend_ovf  = upd_ovf;
                    if (is_slash) begin
                        n_b_valid = 1'b1;
                        n_b_kind  = KIND_WORD_SPACE;
                        n_b_eop   = r_a_eop;
                    end else if (is_space || r_a_eop) begin
                        n_b_valid = 1'b1;
                        n_b_eop   = r_a_eop;
                        if (upd_ovf) begin
                            n_b_kind = KIND_TOO_LONG;
                        end else if (upd_len == '0) begin
                            n_b_kind = KIND_UNKNOWN;
                        end else begin
                            n_b_lookup = 1'b1;
                        end
                    end
                    if (is_slash || is_space || r_a_eop) begin
                        n_pend_bits = '0;
                        n_pend_len  = '0;
                        n_pend_ovf  = 1'b0;
                    end
                end
                FUNC_ENCODE: begin
                    n_b_valid = 1'b1;
                    if (upper == CH_SPACE) begin
                        n_b_kind = KIND_WORD_SEP;
                    end else begin
                        n_b_kind = KIND_CODE;
                        n_b_enc  = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    mtc_tables #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_tables (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_ins      (ins),
        .i_dec_bits (upd_bits),
        .i_dec_len  (upd_len),
        .i_enc_char (upper),
        .i_chk_code (rev.code),
        .i_chk_len  (rev.len),
        .o_busy     (busy),
        .o_dec_char (dec_char),
        .o_rev      (rev),
        .o_chk_char (chk_char)
    );

    // reverse entry counts only if its node still holds this character
    assign enc_hit = r_c_enc && r_c_rev.present && (chk_char == r_c_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
            r_pend_bits <= '0;
            r_pend_len  <= '0;
            r_pend_ovf  <= 1'b0;
        end else if (en) begin
            r_a_valid   <= i_valid;
            r_b_valid   <= n_b_valid;
            r_c_valid   <= r_b_valid;
            r_o_valid   <= r_c_valid;
            r_pend_bits <= n_pend_bits;
            r_pend_len  <= n_pend_len;
            r_pend_ovf  <= n_pend_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_func  <= i_func;
            r_a_char  <= i_char_value;
            r_a_pbits <= i_path_bits;
            r_a_plen  <= i_path_len;
            r_a_eop   <= i_phrase_end;

            r_b_kind   <= n_b_kind;
            r_b_lookup <= n_b_lookup;
            r_b_enc    <= n_b_enc;
            r_b_eop    <= n_b_eop;
            r_b_char   <= upper;

            if (r_b_lookup) begin
                r_c_kind   <= (dec_char != '0) ? KIND_LETTER : KIND_UNKNOWN;
                r_c_letter <= dec_char;
            end else begin
                r_c_kind   <= r_b_kind;
                r_c_letter <= '0;
            end
            r_c_eop  <= r_b_eop;
            r_c_enc  <= r_b_enc;
            r_c_char <= r_b_char;
            r_c_rev  <= rev;

            r_o_kind      <= r_c_kind;
            r_o_letter    <= r_c_letter;
            r_o_code_bits <= enc_hit ? r_c_rev.code : '0;
            r_o_code_len  <= enc_hit ? r_c_rev.len : '0;
            r_o_eop       <= r_c_eop;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_kind          = r_o_kind;
    assign o_letter        = r_o_letter;
    assign o_code_bits     = r_o_code_bits;
    assign o_code_len      = r_o_code_len;
    assign o_end_of_phrase = r_o_eop;

endmodule

`default_nettype wire
